// ===== hw/rtl/rims_pkg.sv =====
// shared types and constants for the run insertion merge sort core
// no dependencies
package rims_pkg;
  localparam int MAX_KEYS = 64;
  localparam int RUN_LEN = 32;
  localparam int KEY_W = 32;
  localparam int ADDR_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } key_item_t;

  function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction
endpackage

// ===== hw/rtl/rims_if.sv =====
// valid/ready channel carrying one key item
// depends on rims_pkg
interface rims_if;
  logic                       valid;
  logic                       ready;
  logic [rims_pkg::KEY_W-1:0] key;
  logic                       last;
  modport source (output valid, key, last, input ready);
  modport sink (input valid, key, last, output ready);
endinterface

// ===== hw/rtl/rims_ram.sv =====
// generic single write, single registered read ram
// no dependencies
module rims_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rims_front.sv =====
// front: accepts key items into a small queue, marks the item that closes the set (last flag or full store)
// depends on rims_pkg
module rims_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rims_pkg::key_item_t in_item,
  output logic                q_valid,
  input  logic                q_pop,
  output rims_pkg::key_item_t q_item
);
  rims_pkg::key_item_t         fifo [rims_pkg::QDEPTH];
  logic [rims_pkg::QPTR_W-1:0] wptr;
  logic [rims_pkg::QPTR_W-1:0] rptr;
  logic [rims_pkg::QPTR_W:0]   fill;
  logic [rims_pkg::CNT_W-1:0]  count;
  logic                        push;
  logic                        pop;
  logic                        ends_set;

  assign in_ready = fill != rims_pkg::QPTR_W'(0) + (rims_pkg::QPTR_W+1)'(rims_pkg::QDEPTH);
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;
  assign q_valid = fill != '0;
  assign q_item = fifo[rptr];
  // the last flag or a full store closes the set
  assign ends_set = in_item.last ||
                    (count == rims_pkg::CNT_W'(rims_pkg::MAX_KEYS - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr].key <= in_item.key;
      fifo[wptr].last <= ends_set;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
        count <= ends_set ? '0 : count + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (rims_pkg::QPTR_W+1)'(push) - (rims_pkg::QPTR_W+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/rims_back.sv =====
// back: stores a set, insertion sorts runs, merges bottom-up, streams result
// depends on rims_pkg, rims_ram
module rims_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  rims_pkg::key_item_t q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rims_pkg::key_item_t out_item
);
  localparam int AW = rims_pkg::ADDR_W;
  localparam int CW = rims_pkg::CNT_W;
  localparam int KW = rims_pkg::KEY_W;
  localparam int WW = CW + 1;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_INS_START = 4'd1;
  localparam logic [3:0] S_INS_RD = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_MRG_START = 4'd4;
  localparam logic [3:0] S_MRG_RDA = 4'd5;
  localparam logic [3:0] S_MRG_RDB = 4'd6;
  localparam logic [3:0] S_MRG_CMP = 4'd7;
  localparam logic [3:0] S_CPY_RD = 4'd8;
  localparam logic [3:0] S_CPY_WR = 4'd9;
  localparam logic [3:0] S_OUT_RD = 4'd10;
  localparam logic [3:0] S_OUT_WAIT = 4'd11;
  localparam logic [3:0] S_OUT = 4'd12;
  localparam logic [3:0] S_INS_RDH = 4'd13;
  localparam logic [3:0] S_INS_HLD = 4'd14;

  logic [3:0]    state;
  logic [CW-1:0] n;
  logic [CW-1:0] lo, hi, i, pos, a, b, mid, k;
  logic [WW-1:0] width;
  logic [KW-1:0] held, ka, kb;
  logic          have_a, have_b;

  logic          s_we, m_we;
  logic [AW-1:0] s_waddr, s_raddr, m_waddr, m_raddr;
  logic [KW-1:0] s_wdata, s_rdata, m_wdata, m_rdata;

  rims_ram #(.WIDTH(KW), .DEPTH(rims_pkg::MAX_KEYS)) u_store (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  rims_ram #(.WIDTH(KW), .DEPTH(rims_pkg::MAX_KEYS)) u_scratch (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  logic [CW+1:0] run_hi, mrg_mid, mrg_hi, nm1;
  assign nm1 = (CW+2)'(n) - 1'b1;
  assign run_hi = (CW+2)'(lo) + (CW+2)'(rims_pkg::RUN_LEN - 1);
  assign mrg_mid = (CW+2)'(lo) + (CW+2)'(width) - 1'b1;
  assign mrg_hi = (CW+2)'(lo) + ((CW+2)'(width) << 1) - 1'b1;

  assign q_pop = state == S_LOAD;
  assign out_valid = state == S_OUT;
  assign out_item.key = s_rdata;
  assign out_item.last = (k == n - 1'b1);

  always_comb begin
    s_we = 1'b0;
    s_waddr = n[AW-1:0];
    s_wdata = q_item.key;
    s_raddr = '0;
    m_we = 1'b0;
    m_waddr = k[AW-1:0];
    m_wdata = ka;
    m_raddr = k[AW-1:0];
    unique case (state)
      S_LOAD: s_we = q_valid;
      S_INS_START: s_raddr = i[AW-1:0];
      S_INS_RDH: s_raddr = i[AW-1:0];
      S_INS_RD: s_raddr = AW'(pos - 1'b1);
      S_INS_CMP: begin
        s_waddr = pos[AW-1:0];
        s_raddr = AW'(pos - 2'd2);
        if (pos > lo && rims_pkg::key_gt(s_rdata, held)) begin
          s_we = 1'b1;
          s_wdata = s_rdata;
        end else begin
          s_we = 1'b1;
          s_wdata = held;
        end
      end
      S_MRG_RDA: s_raddr = a[AW-1:0];
      S_MRG_RDB: s_raddr = b[AW-1:0];
      S_MRG_CMP: begin
        m_we = 1'b1;
        if (have_a && (!have_b || !rims_pkg::key_gt(ka, kb))) begin
          m_wdata = ka;
        end else begin
          m_wdata = kb;
        end
      end
      S_CPY_WR: begin
        s_we = 1'b1;
        s_waddr = k[AW-1:0];
        s_wdata = m_rdata;
      end
      S_OUT_RD: s_raddr = k[AW-1:0];
      S_OUT_WAIT: s_raddr = k[AW-1:0];
      S_OUT: s_raddr = k[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      n <= '0;
    end else begin
      unique case (state)
        S_LOAD: if (q_valid) begin
          n <= n + 1'b1;
          if (q_item.last) begin
            lo <= '0;
            state <= S_INS_START;
          end
        end
        S_INS_START: begin
          if (lo >= n) begin
            width <= WW'(rims_pkg::RUN_LEN);
            lo <= '0;
            state <= S_MRG_START;
          end else begin
            hi <= (run_hi > nm1) ? nm1[CW-1:0] : run_hi[CW-1:0];
            i <= lo + 1'b1;
            state <= S_INS_RDH;
          end
        end
        S_INS_RDH: begin
          if (i > hi) begin
            lo <= lo + CW'(rims_pkg::RUN_LEN);
            state <= S_INS_START;
          end else begin
            pos <= i;
            state <= S_INS_HLD;
          end
        end
        S_INS_HLD: begin
          held <= s_rdata;
          state <= S_INS_RD;
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (pos > lo && rims_pkg::key_gt(s_rdata, held)) begin
            pos <= pos - 1'b1;
            state <= S_INS_RD;
          end else begin
            i <= i + 1'b1;
            state <= S_INS_RDH;
          end
        end
        S_MRG_START: begin
          if ((CW+2)'(width) >= (CW+2)'(n) || (CW+2)'(lo) >= (CW+2)'(n)) begin
            if ((CW+2)'(width) >= (CW+2)'(n)) begin
              k <= '0;
              state <= S_OUT_RD;
            end else begin
              width <= width << 1;
              lo <= '0;
            end
          end else if (mrg_mid >= nm1) begin
            lo <= CW'((CW+2)'(lo) + ((CW+2)'(width) << 1));
          end else begin
            mid <= mrg_mid[CW-1:0];
            hi <= (mrg_hi > nm1) ? nm1[CW-1:0] : mrg_hi[CW-1:0];
            a <= lo;
            b <= mrg_mid[CW-1:0] + 1'b1;
            k <= lo;
            state <= S_MRG_RDA;
          end
        end
        S_MRG_RDA: state <= S_MRG_RDB;
        S_MRG_RDB: begin
          ka <= s_rdata;
          have_a <= a <= mid;
          state <= S_MRG_CMP;
        end
        S_MRG_CMP: begin
          if (have_a && (!have_b || !rims_pkg::key_gt(ka, kb))) begin
            a <= a + 1'b1;
          end else begin
            b <= b + 1'b1;
          end
          if (k == hi) begin
            k <= lo;
            state <= S_CPY_RD;
          end else begin
            k <= k + 1'b1;
            state <= S_MRG_RDA;
          end
        end
        S_CPY_RD: state <= S_CPY_WR;
        S_CPY_WR: begin
          if (k == hi) begin
            lo <= CW'((CW+2)'(lo) + ((CW+2)'(width) << 1));
            state <= S_MRG_START;
          end else begin
            k <= k + 1'b1;
            state <= S_CPY_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: state <= S_OUT;
        S_OUT: if (out_ready) begin
          if (k == n - 1'b1) begin
            n <= '0;
            state <= S_LOAD;
          end else begin
            k <= k + 1'b1;
            state <= S_OUT_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // second operand of a merge step comes straight off the store read port
  always_comb begin
    kb = s_rdata;
    have_b = b <= hi;
  end
endmodule

// ===== hw/rtl/run_insertion_merge_sort_core.sv =====
// sorts up to 64 signed keys a set; one item per cycle while loading
// after the closing item: insertion sort within runs of 32, then bottom-up merge passes
// through a scratch ram; output reads each key from the registered store port
// sync reset empties the queue and the set count
// depends on rims_pkg, rims_if, rims_front, rims_back
module run_insertion_merge_sort_core (
  input logic   clk,
  input logic   rst,
  rims_if.sink  in_ch,
  rims_if.source out_ch
);
  rims_pkg::key_item_t in_item, q_item, out_item;
  logic q_valid, q_pop;

  assign in_item.key = in_ch.key;
  assign in_item.last = in_ch.last;

  rims_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
    .q_valid, .q_pop, .q_item
  );
  rims_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_item,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item
  );

  assign out_ch.key = out_item.key;
  assign out_ch.last = out_item.last;
endmodule

// ===== hw/rtl/rims_checker.sv =====
// port-level checks for the sort core
// depends on run_insertion_merge_sort_core
module rims_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("in valid dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out valid dropped");
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_last)) else $error("last changed");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("valid after reset");
endmodule

bind run_insertion_merge_sort_core rims_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);

// ===== tb/tb.sv =====
// testbench for run_insertion_merge_sort_core: loads key sets, predicts the sorted
// output with its own run-sort model and checks every emitted key
// depends on rims_pkg, rims_if and the core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  rims_if in_ch();
  rims_if out_ch();

  run_insertion_merge_sort_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  typedef logic signed [rims_pkg::KEY_W-1:0] skey_t;

  skey_t pending_keys[$];
  rims_pkg::key_item_t sorted_due[$];
  int err_count = 0;
  int sent_count = 0;
  int seen_count = 0;
  int set_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycle_count = 0;

  // insertion sort of each run, then bottom-up merges, left run wins ties
  task automatic sort_and_expect();
    skey_t store[];
    skey_t scratch[];
    skey_t held;
    rims_pkg::key_item_t item;
    int n, lo, hi, mid, width, p, a, b, k;
    n = pending_keys.size();
    store = new[n];
    scratch = new[n];
    for (int i = 0; i < n; i++) store[i] = pending_keys[i];
    for (lo = 0; lo < n; lo += rims_pkg::RUN_LEN) begin
      hi = (lo + rims_pkg::RUN_LEN - 1 > n - 1) ? n - 1 : lo + rims_pkg::RUN_LEN - 1;
      for (int i = lo + 1; i <= hi; i++) begin
        held = store[i];
        p = i;
        while (p > lo && store[p-1] > held) begin
          store[p] = store[p-1];
          p--;
        end
        store[p] = held;
      end
    end
    for (width = rims_pkg::RUN_LEN; width < n; width *= 2) begin
      for (lo = 0; lo < n; lo += 2 * width) begin
        mid = (lo + width - 1 > n - 1) ? n - 1 : lo + width - 1;
        hi = (lo + 2 * width - 1 > n - 1) ? n - 1 : lo + 2 * width - 1;
        if (mid < hi) begin
          a = lo;
          b = mid + 1;
          k = lo;
          while (a <= mid && b <= hi) begin
            if (!(store[a] > store[b])) scratch[k++] = store[a++];
            else scratch[k++] = store[b++];
          end
          while (a <= mid) scratch[k++] = store[a++];
          while (b <= hi) scratch[k++] = store[b++];
          for (k = lo; k <= hi; k++) store[k] = scratch[k];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      item.key = store[i];
      item.last = (i == n - 1);
      sorted_due.push_back(item);
    end
    pending_keys.delete();
    set_count++;
  endtask

  task automatic send_key(input logic [rims_pkg::KEY_W-1:0] key, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key <= key;
    in_ch.last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_keys.push_back(key);
    sent_count++;
    // a full store closes the set whatever the flag says
    if (last || pending_keys.size() == rims_pkg::MAX_KEYS) sort_and_expect();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [rims_pkg::KEY_W-1:0] rand_key(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(7) << 16;
      2: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom_range(3))};
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  task automatic send_set(input int n, input int mode);
    for (int i = 0; i < n; i++) send_key(rand_key(mode), i == n - 1);
  endtask

  task automatic test_directed();
    send_key(32'h7fff_ffff, 1'b1);
    send_key(32'h8000_0000, 1'b1);
    send_key(32'h7fff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hffff_ffff, 1'b0);
    send_key(32'h0001_0000, 1'b0);
    send_key(32'h0001_0000, 1'b0);
    send_key(32'hffff_0000, 1'b1);
    for (int i = 0; i < 8; i++) send_key(32'h0000_0005, i == 7);
  endtask

  task automatic test_run_edges();
    send_set(32, 0);
    send_set(33, 3);
    // no last flag at all: the store fills and closes the set
    for (int i = 0; i < rims_pkg::MAX_KEYS; i++) send_key(rand_key(i % 4), 1'b0);
  endtask

  task automatic test_random(input int count);
    int n;
    while (count > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(rims_pkg::MAX_KEYS, 33) :
                                     $urandom_range(12, 1);
      send_set(n, $urandom_range(3));
      count -= n;
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        seen_count++;
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected key %h last %b", $time, out_ch.key, out_ch.last);
          err_count++;
        end else begin
          if (out_ch.key !== sorted_due[0].key || out_ch.last !== sorted_due[0].last) begin
            $display("%0t: expected key %h last %b, actual key %h last %b", $time,
                     sorted_due[0].key, sorted_due[0].last, out_ch.key, out_ch.last);
            err_count++;
          end
          void'(sorted_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.key = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 66;
    test_directed();
    test_run_edges();
    test_random(30);
    wait_drained();
    send_idle_pct = 66;
    recv_idle_pct = 36;
    test_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(30);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("tb: %0d keys sent in %0d sets, %0d sorted keys checked", sent_count, set_count,
             seen_count);
    $display("tb: covered extremes, ties, single keys, run boundaries and store-full sets");
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
